// ===== hdl/rsid_pkg.sv =====
package rsid_pkg;

    localparam int SYM_W       = 5;
    localparam int SYM_COUNT   = 17;
    localparam int DATA_COUNT  = 13;
    localparam int PAR_COUNT   = 4;
    localparam int PAR_W       = SYM_W * PAR_COUNT;
    localparam int CODE_W      = 6;
    localparam int ID_W        = 64;
    localparam int SYMS_LO_W   = 60;
    localparam int SYMS_HI_W   = 25;
    localparam int SYMS_W      = SYMS_LO_W + SYMS_HI_W;
    localparam int S_TDATA_W   = 64;
    localparam int M_TDATA_W   = 88;
    localparam int MASK0_W     = 60;
    localparam int MASK1_W     = 42;
    localparam int MASK_W      = MASK0_W + MASK1_W;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 60;

    typedef logic [SYM_W-1:0]  sym_t;
    typedef logic [CODE_W-1:0] code_t;
    typedef logic [PAR_W-1:0]  par_t;

    localparam logic [CFG_INDEX_W-1:0] CFG_MASK_LO = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MASK_HI = 2'd1;

    localparam code_t CODE_ANY    = 6'd32;
    localparam code_t CODE_DIGIT  = 6'd33;
    localparam code_t CODE_LETTER = 6'd34;
    localparam sym_t  LETTER_FIRST = 5'd8;

    localparam logic [MASK0_W-1:0] MASK0_RESET = {10{CODE_ANY}};
    localparam logic [MASK1_W-1:0] MASK1_RESET = {7{CODE_ANY}};

    localparam logic [5:0] FIELD_POLY = 6'h25;
    localparam sym_t TAP0 = 5'd17;
    localparam sym_t TAP1 = 5'd9;
    localparam sym_t TAP2 = 5'd6;
    localparam sym_t TAP3 = 5'd30;

    typedef logic [4:0] order_t [SYM_COUNT];
    localparam order_t OUT_ORDER = '{5'd3, 5'd2, 5'd1, 5'd0, 5'd7, 5'd6, 5'd5, 5'd4,
                                     5'd13, 5'd14, 5'd15, 5'd16, 5'd12, 5'd8, 5'd9,
                                     5'd10, 5'd11};

    function automatic sym_t gf_mul(sym_t x, sym_t y);
        logic [5:0] a;
        sym_t       b;
        sym_t       acc;
        a   = {1'b0, x};
        b   = y;
        acc = '0;
        for (int k = 0; k < SYM_W; k++) begin
            if (b[0]) begin
                acc = acc ^ a[SYM_W-1:0];
            end
            b = b >> 1;
            a = a << 1;
            if (a[SYM_W]) begin
                a = a ^ FIELD_POLY;
            end
        end
        return acc;
    endfunction

    // serial lfsr division, used only to build the parity columns
    function automatic par_t lfsr_parity(logic [ID_W-1:0] id);
        sym_t cw  [DATA_COUNT];
        sym_t par [PAR_COUNT];
        sym_t fb;
        for (int i = 0; i < DATA_COUNT; i++) begin
            cw[i] = sym_t'(id >> (SYM_W * i));
        end
        for (int k = 0; k < PAR_COUNT; k++) begin
            par[k] = '0;
        end
        for (int i = DATA_COUNT - 1; i >= 0; i--) begin
            fb     = cw[i] ^ par[3];
            par[3] = par[2] ^ gf_mul(TAP3, fb);
            par[2] = par[1] ^ gf_mul(TAP2, fb);
            par[1] = par[0] ^ gf_mul(TAP1, fb);
            par[0] = gf_mul(TAP0, fb);
        end
        return {par[3], par[2], par[1], par[0]};
    endfunction

    typedef par_t par_cols_t [ID_W];

    function automatic par_cols_t build_par_cols();
        par_cols_t cols;
        for (int b = 0; b < ID_W; b++) begin
            cols[b] = lfsr_parity(ID_W'(1) << b);
        end
        return cols;
    endfunction

    localparam par_cols_t PAR_COLS = build_par_cols();

    // parity is linear in the id bits: xor of one column per set bit
    function automatic par_t parity_of(logic [ID_W-1:0] id);
        par_t acc;
        acc = '0;
        for (int b = 0; b < ID_W; b++) begin
            if (id[b]) begin
                acc = acc ^ PAR_COLS[b];
            end
        end
        return acc;
    endfunction

    function automatic logic code_accepts(code_t code, sym_t sym);
        logic hit;
        if (!code[CODE_W-1]) begin
            hit = (code[SYM_W-1:0] == sym);
        end else begin
            unique case (code)
                CODE_ANY:    hit = 1'b1;
                CODE_DIGIT:  hit = (sym < LETTER_FIRST);
                CODE_LETTER: hit = (sym >= LETTER_FIRST);
                default:     hit = 1'b0;
            endcase
        end
        return hit;
    endfunction

endpackage

// ===== hdl/rs_gf32_id_encode_and_mask_match_top.sv =====
// channel   dir  handshake              payload
// s_        in   s_tvalid / s_tready    account number
// m_        out  m_tvalid / m_tready    17 encoded symbols, mask match flag
// cfg_      in   cfg_valid / cfg_ready  mask register index and data
//
// one request per cycle unless the result is stalled; a taken request passes
// through input register, xor parity network and mask compare, result register
// aresetn clears both valid flags and sets every mask code to any
// a stalled result holds in the result register while one more request
// waits in the input register; cfg_ready is always high
module rs_gf32_id_encode_and_mask_match_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [rsid_pkg::S_TDATA_W-1:0]      s_tdata,   // account_number
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [rsid_pkg::M_TDATA_W-1:0]      m_tdata,   // symbols_0_to_11,
                                                           // symbols_12_to_16,
                                                           // mask_matched, zero pad
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rsid_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [rsid_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import rsid_pkg::*;

    logic                 in_valid_reg;
    logic [ID_W-1:0]      in_id_reg;
    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic [M_TDATA_W-1:0] out_data_next;
    logic [MASK0_W-1:0]   mask0_reg;
    logic [MASK1_W-1:0]   mask1_reg;

    logic                 out_free;
    par_t                 parity;
    sym_t                 cw  [SYM_COUNT];
    sym_t                 sym [SYM_COUNT];
    logic [SYM_COUNT-1:0] hit;
    logic [MASK_W-1:0]    mask_all;
    logic [SYMS_W-1:0]    syms_flat;

    assign out_free  = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || out_free;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign mask_all  = {mask1_reg, mask0_reg};

    always_comb begin
        parity = parity_of(in_id_reg);
        for (int i = 0; i < DATA_COUNT - 1; i++) begin
            cw[i] = in_id_reg[SYM_W*i +: SYM_W];
        end
        cw[DATA_COUNT-1] = {1'b0, in_id_reg[ID_W-1 -: SYM_W-1]};
        for (int k = 0; k < PAR_COUNT; k++) begin
            cw[DATA_COUNT+k] = parity[SYM_W*k +: SYM_W];
        end
        for (int i = 0; i < SYM_COUNT; i++) begin
            sym[i] = cw[OUT_ORDER[i]];
            hit[i] = code_accepts(mask_all[CODE_W*i +: CODE_W], sym[i]);
            syms_flat[SYM_W*i +: SYM_W] = sym[i];
        end
        out_data_next = {{(M_TDATA_W - SYMS_W - 1){1'b0}}, &hit, syms_flat};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mask0_reg     <= MASK0_RESET;
            mask1_reg     <= MASK1_RESET;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_MASK_LO) begin
                    mask0_reg <= cfg_data[MASK0_W-1:0];
                end else if (cfg_index == CFG_MASK_HI) begin
                    mask1_reg <= cfg_data[MASK1_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_id_reg <= s_tdata;
        end
        if (out_free && in_valid_reg) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

// ===== hdl/rsid_checker.sv =====
module rsid_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [rsid_pkg::M_TDATA_W-1:0] m_tdata
);
    import rsid_pkg::*;

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[M_TDATA_W-1:SYMS_W+1] == '0)
        else $error("result pad bits not zero");

    a_result_from_request: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result without a request two cycles before");

    a_ready_when_out_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

endmodule

bind rs_gf32_id_encode_and_mask_match_top rsid_checker u_rsid_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/tb_rs_gf32_id_encode_and_mask_match_top.sv =====
`timescale 1ns / 100ps

module tb_rs_gf32_id_encode_and_mask_match_top;

    import rsid_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 95;
    localparam int IDLE_PCT     = 7;
    localparam int REPORT_LIMIT = 10;

    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_B = 2'd3;

    localparam code_t CODE_UNUSED_FIRST = 6'd35;
    localparam code_t CODE_UNUSED_LAST  = 6'd63;

    class codeword_scoreboard;
        logic [MASK0_W-1:0]   mask_lo;
        logic [MASK1_W-1:0]   mask_hi;
        logic [M_TDATA_W-1:0] pending_codewords [$];
        int                   mismatch_count;

        function new();
            mask_lo        = MASK0_RESET;
            mask_hi        = MASK1_RESET;
            mismatch_count = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            if (index == CFG_MASK_LO) begin
                mask_lo = data[MASK0_W-1:0];
            end else if (index == CFG_MASK_HI) begin
                mask_hi = data[MASK1_W-1:0];
            end
        endfunction

        // horner form, msb of x first
        function sym_t gf_times(sym_t x, sym_t y);
            logic [SYM_W:0] prod;
            prod = '0;
            for (int k = SYM_W - 1; k >= 0; k--) begin
                prod = prod << 1;
                if (prod[SYM_W]) begin
                    prod = prod ^ FIELD_POLY;
                end
                if (x[k]) begin
                    prod = prod ^ {1'b0, y};
                end
            end
            return prod[SYM_W-1:0];
        endfunction

        function logic code_hit(code_t code, sym_t s);
            if (code < CODE_ANY) begin
                return code[SYM_W-1:0] == s;
            end
            case (code)
                CODE_ANY:    return 1'b1;
                CODE_DIGIT:  return s < LETTER_FIRST;
                CODE_LETTER: return s >= LETTER_FIRST;
                default:     return 1'b0;
            endcase
        endfunction

        function logic [M_TDATA_W-1:0] encode_account(logic [ID_W-1:0] acct);
            sym_t                 cw  [SYM_COUNT];
            sym_t                 rem [PAR_COUNT];
            sym_t                 fb;
            sym_t                 s;
            code_t                code;
            logic                 matched;
            logic [M_TDATA_W-1:0] word;
            word    = '0;
            matched = 1'b1;
            for (int i = 0; i < DATA_COUNT; i++) begin
                cw[i] = sym_t'(acct >> (SYM_W * i));
            end
            for (int k = 0; k < PAR_COUNT; k++) begin
                rem[k] = '0;
            end
            for (int i = DATA_COUNT - 1; i >= 0; i--) begin
                fb     = cw[i] ^ rem[3];
                rem[3] = rem[2] ^ gf_times(TAP3, fb);
                rem[2] = rem[1] ^ gf_times(TAP2, fb);
                rem[1] = rem[0] ^ gf_times(TAP1, fb);
                rem[0] = gf_times(TAP0, fb);
            end
            for (int k = 0; k < PAR_COUNT; k++) begin
                cw[DATA_COUNT + k] = rem[k];
            end
            for (int p = 0; p < SYM_COUNT; p++) begin
                s = cw[OUT_ORDER[p]];
                word[SYM_W*p +: SYM_W] = s;
                if (p < 10) begin
                    code = mask_lo[CODE_W*p +: CODE_W];
                end else begin
                    code = mask_hi[CODE_W*(p-10) +: CODE_W];
                end
                if (!code_hit(code, s)) begin
                    matched = 1'b0;
                end
            end
            word[SYMS_W] = matched;
            return word;
        endfunction

        function void note_request(logic [ID_W-1:0] acct);
            pending_codewords.push_back(encode_account(acct));
        endfunction

        function void report(string what, logic [63:0] want, logic [63:0] got);
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
                $display("mismatch %s: expected %h actual %h", what, want, got);
            end
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] got);
            logic [M_TDATA_W-1:0] want;
            if (pending_codewords.size() == 0) begin
                report("unrequested result", '0, got[63:0]);
                return;
            end
            want = pending_codewords.pop_front();
            if (got[SYMS_LO_W-1:0] !== want[SYMS_LO_W-1:0]) begin
                report("symbols_0_to_11", 64'(want[SYMS_LO_W-1:0]),
                       64'(got[SYMS_LO_W-1:0]));
            end
            if (got[SYMS_W-1:SYMS_LO_W] !== want[SYMS_W-1:SYMS_LO_W]) begin
                report("symbols_12_to_16", 64'(want[SYMS_W-1:SYMS_LO_W]),
                       64'(got[SYMS_W-1:SYMS_LO_W]));
            end
            if (got[SYMS_W] !== want[SYMS_W]) begin
                report("mask_matched", 64'(want[SYMS_W]), 64'(got[SYMS_W]));
            end
        endfunction

        function int pending_count();
            return pending_codewords.size();
        endfunction
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    codeword_scoreboard     ledger;
    bit                     steady_in;
    bit                     steady_out;
    int                     cycle_count;

    logic [ID_W-1:0]        seed;
    logic [MASK0_W-1:0]     lo_codes;
    logic [MASK1_W-1:0]     hi_codes;
    logic [CFG_DATA_W-MASK1_W-1:0] spare_bits;

    rs_gf32_id_encode_and_mask_match_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_tready <= steady_out ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            ledger.check_result(m_tdata);
        end
    end

    task automatic send_account(logic [ID_W-1:0] acct);
        while (!steady_in && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= acct;
        do @(posedge aclk); while (!s_tready);
        ledger.note_request(acct);
        @(negedge aclk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        ledger.write_reg(index, data);
        @(negedge aclk);
    endtask

    task automatic drain_and_settle();
        while (ledger.pending_count() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(negedge aclk);
    endtask

    function automatic void build_mask(input logic [M_TDATA_W-1:0] target, input bit clean,
                                       output logic [MASK0_W-1:0] m_lo,
                                       output logic [MASK1_W-1:0] m_hi);
        sym_t  s;
        code_t c;
        int    kind;
        for (int p = 0; p < SYM_COUNT; p++) begin
            s    = target[SYM_W*p +: SYM_W];
            kind = clean ? $urandom_range(0, 15) : $urandom_range(0, 19);
            if (kind <= 7) begin
                c = code_t'(s);
            end else if (kind <= 11) begin
                c = CODE_ANY;
            end else if (kind <= 15) begin
                c = (s < LETTER_FIRST) ? CODE_DIGIT : CODE_LETTER;
            end else if (kind == 16) begin
                c = (s < LETTER_FIRST) ? CODE_LETTER : CODE_DIGIT;
            end else if (kind == 17) begin
                c = code_t'($urandom_range(CODE_UNUSED_FIRST, CODE_UNUSED_LAST));
            end else if (kind == 18) begin
                c = code_t'($urandom_range(0, 31));
            end else begin
                c = code_t'($urandom_range(0, 63));
            end
            if (p < 10) begin
                m_lo[CODE_W*p +: CODE_W] = c;
            end else begin
                m_hi[CODE_W*(p-10) +: CODE_W] = c;
            end
        end
    endfunction

    function automatic logic [ID_W-1:0] pick_account(logic [ID_W-1:0] base);
        int r;
        int k;
        r = $urandom_range(0, 99);
        k = $urandom_range(0, ID_W - 1);
        if (r < 35) begin
            return base;
        end
        if (r < 50) begin
            return base ^ (ID_W'(1) << k);
        end
        if (r < 60) begin
            case ($urandom_range(0, 3))
                0:       return '0;
                1:       return '1;
                2:       return ID_W'(1) << k;
                default: return ~(ID_W'(1) << k);
            endcase
        end
        return {$urandom, $urandom};
    endfunction

    initial begin
        ledger      = new();
        cycle_count = 0;
        steady_in   = 1'b0;
        steady_out  = 1'b0;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_MASK_LO;
        cfg_data    = '0;

        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset masks: every position any
        send_account(64'h0000_0000_0000_0000);
        send_account(64'hFFFF_FFFF_FFFF_FFFF);
        send_account(64'h0000_0000_0000_0001);
        send_account(64'h8000_0000_0000_0000);
        send_account(64'h5555_5555_5555_5555);
        send_account(64'hAAAA_AAAA_AAAA_AAAA);
        send_account(64'h0000_0000_0000_001F);
        send_account(64'h0000_0000_0000_0020);
        send_account(64'hF000_0000_0000_0000);
        send_account(64'h0FFF_FFFF_FFFF_FFFF);
        send_account(64'h7FFF_FFFF_FFFF_FFFF);
        send_account(64'hFFFF_FFFF_FFFF_FFFE);
        send_account(64'h0842_1084_2108_4210);
        send_account(64'h1084_2108_4210_8421);
        send_account(64'h0123_4567_89AB_CDEF);

        for (int ph = 0; ph < PHASES; ph++) begin
            seed = {$urandom, $urandom};
            case (ph)
                0: begin
                    seed     = '0;
                    lo_codes = '0;
                    hi_codes = '0;
                end
                1: begin
                    lo_codes = '1;
                    hi_codes = '1;
                end
                2: begin
                    lo_codes = {10{CODE_DIGIT}};
                    hi_codes = {7{CODE_DIGIT}};
                end
                3: begin
                    lo_codes = {10{CODE_LETTER}};
                    hi_codes = {7{CODE_LETTER}};
                end
                4: begin
                    lo_codes = MASK0_RESET;
                    hi_codes = MASK1_RESET;
                end
                default: begin
                    build_mask(ledger.encode_account(seed), ph % 2 == 1, lo_codes, hi_codes);
                end
            endcase

            s_tvalid <= 1'b0;
            drain_and_settle();
            steady_in  = (ph == 2 || ph == 3);
            steady_out = (ph == 2 || ph == 3);

            if (ph == 5) begin
                write_reg(CFG_UNUSED_A, CFG_DATA_W'({$urandom, $urandom}));
            end else if (ph == 6) begin
                write_reg(CFG_UNUSED_B, CFG_DATA_W'({$urandom, $urandom}));
            end else if (ph > 6 && $urandom_range(0, 2) == 0) begin
                write_reg($urandom_range(0, 1) ? CFG_UNUSED_A : CFG_UNUSED_B,
                          CFG_DATA_W'({$urandom, $urandom}));
            end
            spare_bits = (ph == 1) ? '1 : (CFG_DATA_W - MASK1_W)'($urandom);
            write_reg(CFG_MASK_LO, lo_codes);
            write_reg(CFG_MASK_HI, {spare_bits, hi_codes});
            cfg_valid <= 1'b0;

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_account(pick_account(seed));
            end
        end

        s_tvalid   <= 1'b0;
        steady_in  = 1'b0;
        steady_out = 1'b0;
        while (ledger.pending_count() != 0) begin
            @(posedge aclk);
        end
        repeat (6) @(posedge aclk);

        if (ledger.mismatch_count == 0 && ledger.pending_count() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/rsid_pkg.sv
hdl/rs_gf32_id_encode_and_mask_match_top.sv
hdl/rsid_checker.sv
tb/tb_rs_gf32_id_encode_and_mask_match_top.sv
